[rtl/core/glu_pkg.sv]
package glu_pkg;

   // width of the operand and answer ports
   localparam int unsigned PORT_WIDTH = 32;

   // mode codes
   localparam logic MODE_GCD = 1'b0;
   localparam logic MODE_LCM = 1'b1;

   // gcd answer when both operands are zero
   localparam logic [PORT_WIDTH-1:0] ANSWER_BOTH_ZERO = '1;

   // operation of the shared adder
   typedef enum logic {
      UNIT_ADD,
      UNIT_SUB
   } unit_op_type;

endpackage

[rtl/core/glu_addsub.sv]
module glu_addsub
   import glu_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  unit_op_type      op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH:0]   sum
);

   logic [WIDTH:0] b_ext;
   logic           carry;

   // subtract as add of the inverted operand plus one; top bit is the borrow
   always_comb begin
      b_ext = {1'b0, b};
      carry = 1'b0;
      unique case (op)
         UNIT_ADD: begin
            b_ext = {1'b0, b};
            carry = 1'b0;
         end
         UNIT_SUB: begin
            b_ext = ~{1'b0, b};
            carry = 1'b1;
         end
         default: begin
            b_ext = {1'b0, b};
            carry = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, a} + b_ext + {{WIDTH{1'b0}}, carry};

endmodule

[rtl/core/gcd_lcm_unit.sv]
// channel   | ports                                            | direction
// ----------+--------------------------------------------------+----------
// request   | start, busy, req_mode, req_first_operand,        | in (busy out)
//           | req_second_operand                               |
// response  | rsp_valid, rsp_answer, rsp_overflow              | out
//
// a word is taken when start is high and busy is low; the answer appears
// with rsp_valid for one cycle, and busy drops in that same cycle.
// operand arithmetic uses one DATA_WIDTH+1 bit adder, one step a cycle.
// gcd: sign removal (ST_ABS_A, ST_ABS_B) and zero checks (ST_CHECK), where
// a zero operand answers at once; else a binary gcd loop of one subtract,
// shift or swap per cycle (data dependent), then a scale step (ST_SCALE); the
// answer strobe follows in the next cycle. lcm adds restoring division
// (ST_DIVIDE), shift-add multiply (ST_MULTIPLY) and a sign step (ST_FINISH).
// synchronous reset returns the sequencer to idle; the receiver cannot stall.
module gcd_lcm_unit
   import glu_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_mode,
   input  logic signed [PORT_WIDTH-1:0] req_first_operand,
   input  logic signed [PORT_WIDTH-1:0] req_second_operand,
   output logic                         rsp_valid,
   output logic signed [PORT_WIDTH-1:0] rsp_answer,
   output logic                         rsp_overflow
);

   localparam int unsigned CW = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS_A,
      ST_ABS_B,
      ST_CHECK,
      ST_REDUCE,
      ST_SCALE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic                    neg_a_ff, neg_a_in;
   logic                    neg_b_ff, neg_b_in;
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   y_ff, y_in;
   logic [DATA_WIDTH-1:0]   ma_ff, ma_in;
   logic [DATA_WIDTH-1:0]   mb_ff, mb_in;
   logic [DATA_WIDTH-1:0]   g_ff, g_in;
   logic [CW-1:0]           k_ff, k_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PORT_WIDTH-1:0]   rsp_answer_ff, rsp_answer_in;
   logic                    rsp_overflow_ff, rsp_overflow_in;

   unit_op_type             unit_op;
   logic [DATA_WIDTH-1:0]   unit_a;
   logic [DATA_WIDTH-1:0]   unit_b;
   logic [DATA_WIDTH:0]     unit_sum;
   logic                    borrow;
   logic [DATA_WIDTH-1:0]   rem_shift;
   logic [DATA_WIDTH-1:0]   scaled;
   logic [DATA_WIDTH-1:0]   lcm_low;
   logic                    lcm_neg;
   logic                    lcm_ovf;

   // operand selection for the shared adder
   always_comb begin
      unit_op = UNIT_SUB;
      unit_a  = x_ff;
      unit_b  = y_ff;
      unique case (state_ff)
         ST_ABS_A: begin
            unit_a = '0;
            unit_b = x_ff;
         end
         ST_ABS_B: begin
            unit_a = '0;
            unit_b = y_ff;
         end
         ST_DIVIDE: begin
            unit_a = rem_shift;
            unit_b = g_ff;
         end
         ST_MULTIPLY: begin
            unit_op = UNIT_ADD;
            unit_a  = y_ff;
            unit_b  = mb_ff;
         end
         ST_FINISH: begin
            unit_a = '0;
            unit_b = x_ff;
         end
         default: begin
            unit_op = UNIT_SUB;
            unit_a  = x_ff;
            unit_b  = y_ff;
         end
      endcase
   end

   glu_addsub #(
      .WIDTH (DATA_WIDTH)
   ) u_glu_addsub (
      .op  (unit_op),
      .a   (unit_a),
      .b   (unit_b),
      .sum (unit_sum)
   );

   assign borrow    = unit_sum[DATA_WIDTH];
   assign rem_shift = {y_ff[DATA_WIDTH-2:0], x_ff[DATA_WIDTH-1]};
   assign scaled    = x_ff << k_ff;

   // sign and range of the lcm product held as {y, x}
   assign lcm_neg = neg_a_ff ^ neg_b_ff;
   assign lcm_low = lcm_neg ? unit_sum[DATA_WIDTH-1:0] : x_ff;
   assign lcm_ovf = lcm_neg
      ? ((y_ff != '0) || (x_ff[DATA_WIDTH-1] && (x_ff[DATA_WIDTH-2:0] != '0)))
      : ((y_ff != '0) || x_ff[DATA_WIDTH-1]);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      neg_a_in        = neg_a_ff;
      neg_b_in        = neg_b_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      ma_in           = ma_ff;
      mb_in           = mb_ff;
      g_in            = g_ff;
      k_in            = k_ff;
      count_in        = count_ff;
      rsp_valid_in    = 1'b0;
      rsp_answer_in   = rsp_answer_ff;
      rsp_overflow_in = rsp_overflow_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               x_in     = req_first_operand[DATA_WIDTH-1:0];
               y_in     = req_second_operand[DATA_WIDTH-1:0];
               neg_a_in = req_first_operand[DATA_WIDTH-1];
               neg_b_in = req_second_operand[DATA_WIDTH-1];
               state_in = ST_ABS_A;
            end
         end
         // magnitudes, taken as unsigned
         ST_ABS_A: begin
            x_in     = neg_a_ff ? unit_sum[DATA_WIDTH-1:0] : x_ff;
            ma_in    = x_in;
            state_in = ST_ABS_B;
         end
         ST_ABS_B: begin
            y_in     = neg_b_ff ? unit_sum[DATA_WIDTH-1:0] : y_ff;
            mb_in    = y_in;
            state_in = ST_CHECK;
         end
         // zero operands settle the answer at once
         ST_CHECK: begin
            k_in = '0;
            if (mode_ff == MODE_GCD) begin
               priority if ((ma_ff == '0) && (mb_ff == '0)) begin
                  rsp_answer_in   = ANSWER_BOTH_ZERO;
                  rsp_overflow_in = 1'b0;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end else if (ma_ff == '0) begin
                  rsp_answer_in   = PORT_WIDTH'($signed(mb_ff));
                  rsp_overflow_in = mb_ff[DATA_WIDTH-1];
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end else if (mb_ff == '0) begin
                  rsp_answer_in   = PORT_WIDTH'($signed(ma_ff));
                  rsp_overflow_in = ma_ff[DATA_WIDTH-1];
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end else begin
               if ((ma_ff == '0) || (mb_ff == '0)) begin
                  rsp_answer_in   = '0;
                  rsp_overflow_in = 1'b0;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         // binary gcd, one step a cycle
         ST_REDUCE: begin
            priority if (!x_ff[0] && !y_ff[0]) begin
               x_in = {1'b0, x_ff[DATA_WIDTH-1:1]};
               y_in = {1'b0, y_ff[DATA_WIDTH-1:1]};
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[DATA_WIDTH-1:1]};
            end else if (!y_ff[0]) begin
               y_in = {1'b0, y_ff[DATA_WIDTH-1:1]};
            end else if (unit_sum == '0) begin
               state_in = ST_SCALE;
            end else if (borrow) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = unit_sum[DATA_WIDTH:1];
            end
         end
         // restore common factors of two
         ST_SCALE: begin
            g_in = scaled;
            if (mode_ff == MODE_GCD) begin
               rsp_answer_in   = PORT_WIDTH'($signed(scaled));
               rsp_overflow_in = scaled[DATA_WIDTH-1];
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               x_in     = ma_ff;
               y_in     = '0;
               count_in = LAST_BIT;
               state_in = ST_DIVIDE;
            end
         end
         // restoring division, quotient shifts into x
         ST_DIVIDE: begin
            x_in     = {x_ff[DATA_WIDTH-2:0], ~borrow};
            y_in     = borrow ? rem_shift : unit_sum[DATA_WIDTH-1:0];
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               y_in     = '0;
               count_in = LAST_BIT;
               state_in = ST_MULTIPLY;
            end
         end
         // shift-add multiply, product in {y, x}
         ST_MULTIPLY: begin
            if (x_ff[0]) begin
               y_in = unit_sum[DATA_WIDTH:1];
               x_in = {unit_sum[0], x_ff[DATA_WIDTH-1:1]};
            end else begin
               y_in = {1'b0, y_ff[DATA_WIDTH-1:1]};
               x_in = {y_ff[0], x_ff[DATA_WIDTH-1:1]};
            end
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         // apply sign and range check
         ST_FINISH: begin
            rsp_answer_in   = PORT_WIDTH'($signed(lcm_low));
            rsp_overflow_in = lcm_ovf;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, datapath registers and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff         <= mode_in;
      neg_a_ff        <= neg_a_in;
      neg_b_ff        <= neg_b_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      ma_ff           <= ma_in;
      mb_ff           <= mb_in;
      g_ff            <= g_in;
      k_ff            <= k_in;
      count_ff        <= count_in;
      rsp_answer_ff   <= rsp_answer_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_answer   = rsp_answer_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[rtl/core/glu_checker.sv]
module glu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // reset leaves the unit idle with no answer pending
   assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("unit not idle after reset");

   // an accepted word makes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("word accepted but unit not busy");

   // busy drops only together with an answer strobe
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without an answer");

   // answers never arrive while a word is still in work, and a strobe never comes twice in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("answer strobe while busy or repeated");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
